### rtl/gsa_pkg.sv
package gsa_pkg;

  // Pool geometry
  localparam int SLOTS  = 64;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int SALT_W = 16;
  localparam int FUNC_W = 2;

  // Stream payload widths, padded to whole bytes
  localparam int DATA_W = ((IDX_W + SALT_W + 7) / 8) * 8;

  // Operation codes carried in the request tuser
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC  = 2'd0,
    FUNC_FREE   = 2'd1,
    FUNC_LOOKUP = 2'd2
  } func_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // request taken, generation read issued
    logic exec;   // read data ready, update state and result
  } gsa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // result register empty or draining this cycle
  } gsa_status_t;

endpackage

### rtl/generational_slot_allocator.sv
// Channel  | dir | tdata (low bit up)                 | tuser
// ---------+-----+------------------------------------+----------------------
// s_*      | in  | handle_index, handle_salt, zero pad | func (0 alloc, 1 free, 2 lookup)
// m_*      | out | result_index, result_salt, zero pad | ok
//
// At most one request in flight: the accept cycle reads the generation memory,
// the next cycle updates slot state and loads the result register.
// A request is taken only while the result register is empty or draining.
// rst is synchronous; live bits and counters clear at once, generations
// read as zero until a slot is first freed.
module generational_slot_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [gsa_pkg::DATA_W-1:0]   s_tdata,  // handle_index, handle_salt, pad
  input  logic [gsa_pkg::FUNC_W-1:0]   s_tuser,  // func
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [gsa_pkg::DATA_W-1:0]   m_tdata,  // result_index, result_salt, pad
  output logic [0:0]                   m_tuser   // ok
);
  import gsa_pkg::*;

  gsa_cmd_t    cmd;
  gsa_status_t status;

  gsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  gsa_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // No new request while a result is stuck
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("request taken while result stalled");

  // A taken request gets a valid result once its execute state loads the result register
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> ##2 m_tvalid)
    else $error("result missing after request");

  // Requests are not taken on consecutive edges
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("back to back request taken");

endmodule

### rtl/gsa_ctrl.sv
module gsa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  gsa_pkg::gsa_status_t status,
  output gsa_pkg::gsa_cmd_t    cmd
);
  import gsa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Take a request only when the result register can hold its answer
  assign s_tready = (state == ST_IDLE) && status.out_free;
  assign cmd.load = s_tvalid && s_tready;
  assign cmd.exec = (state == ST_EXEC);

  // Next state
  always_comb begin
    case (state)
      ST_IDLE: state_next = cmd.load ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/gsa_datapath.sv
module gsa_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  gsa_pkg::gsa_cmd_t            cmd,
  output gsa_pkg::gsa_status_t         status,
  input  logic [gsa_pkg::DATA_W-1:0]   s_tdata,
  input  logic [gsa_pkg::FUNC_W-1:0]   s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [gsa_pkg::DATA_W-1:0]   m_tdata,
  output logic [0:0]                   m_tuser
);
  import gsa_pkg::*;

  // Slot state
  logic [SLOTS-1:0]  live;
  logic [SLOTS-1:0]  gen_written;   // generation entry written since reset, else it reads as zero
  logic [SALT_W-1:0] gen_mem [SLOTS];
  logic [CNT_W-1:0]  hwc;
  logic [CNT_W-1:0]  live_total;

  // Request registers
  func_t             req_func;
  logic [IDX_W-1:0]  req_addr;
  logic [SALT_W-1:0] req_salt;
  logic              req_alloc_ok;
  logic              req_use_top;
  logic [SALT_W-1:0] rd_q;
  logic              rd_written_q;

  // Result register
  logic              out_ok;
  logic [IDX_W-1:0]  out_idx;
  logic [SALT_W-1:0] out_salt;

  // Incoming fields
  logic [IDX_W-1:0]  in_idx;
  logic [SALT_W-1:0] in_salt;
  func_t             in_func;

  assign in_idx  = s_tdata[IDX_W-1:0];
  assign in_salt = s_tdata[IDX_W+SALT_W-1:IDX_W];
  assign in_func = func_t'(s_tuser);

  // Lowest dead slot
  function automatic logic [IDX_W-1:0] first_dead(input logic [SLOTS-1:0] lv);
    logic [IDX_W-1:0] pos;
    pos = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!lv[i]) pos = IDX_W'(i);
    end
    return pos;
  endfunction

  // Allocation choice from current state
  logic [IDX_W-1:0] hole;
  logic             hole_found;
  logic             use_top;
  logic             alloc_ok;
  logic [IDX_W-1:0] alloc_addr;

  always_comb begin
    hole       = first_dead(live);
    hole_found = !(&live) && ({1'b0, hole} < hwc);
    use_top    = (live_total >= hwc);
    if (use_top) begin
      alloc_ok   = (hwc < CNT_W'(SLOTS));
      alloc_addr = hwc[IDX_W-1:0];
    end else begin
      alloc_ok   = hole_found;
      alloc_addr = hole;
    end
  end

  // Capture request and read generation memory
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_func     <= in_func;
      req_salt     <= in_salt;
      req_alloc_ok <= alloc_ok;
      req_use_top  <= use_top;
      if (in_func == FUNC_ALLOC) begin
        req_addr     <= alloc_addr;
        rd_q         <= gen_mem[alloc_addr];
        rd_written_q <= gen_written[alloc_addr];
      end else begin
        req_addr     <= in_idx;
        rd_q         <= gen_mem[in_idx];
        rd_written_q <= gen_written[in_idx];
      end
    end
  end

  // Execute stage decisions
  logic [SALT_W-1:0] rd_gen;
  logic              in_range;
  logic              free_ok;
  logic              lookup_ok;
  logic              is_top;

  always_comb begin
    rd_gen    = rd_written_q ? rd_q : '0;
    in_range  = ({1'b0, req_addr} < hwc);
    free_ok   = in_range && live[req_addr];
    lookup_ok = in_range && (rd_gen == req_salt);
    is_top    = (({1'b0, req_addr} + CNT_W'(1)) == hwc);
  end

  // Generation write on a successful free
  always_ff @(posedge clk) begin
    if (cmd.exec && (req_func == FUNC_FREE) && free_ok) begin
      gen_mem[req_addr] <= rd_gen + SALT_W'(1);
    end
  end

  // Control state of the pool
  always_ff @(posedge clk) begin
    if (rst) begin
      live        <= '0;
      gen_written <= '0;
      hwc         <= '0;
      live_total  <= '0;
    end else if (cmd.exec) begin
      case (req_func)
        FUNC_ALLOC: begin
          if (req_alloc_ok) begin
            live[req_addr] <= 1'b1;
            live_total     <= live_total + CNT_W'(1);
            if (req_use_top) hwc <= hwc + CNT_W'(1);
          end
        end
        FUNC_FREE: begin
          if (free_ok) begin
            live[req_addr]        <= 1'b0;
            gen_written[req_addr] <= 1'b1;
            if (is_top) hwc <= hwc - CNT_W'(1);
            if (live_total != '0) live_total <= live_total - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.exec) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_ok   <= 1'b0;
      out_idx  <= '0;
      out_salt <= '0;
      case (req_func)
        FUNC_ALLOC: begin
          if (req_alloc_ok) begin
            out_ok   <= 1'b1;
            out_idx  <= req_addr;
            out_salt <= rd_gen;
          end
        end
        FUNC_FREE: begin
          out_ok <= free_ok;
        end
        FUNC_LOOKUP: begin
          if (lookup_ok) begin
            out_ok   <= 1'b1;
            out_idx  <= req_addr;
            out_salt <= rd_gen;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign m_tuser         = out_ok;
  assign m_tdata         = {{(DATA_W - IDX_W - SALT_W){1'b0}}, out_salt, out_idx};
  assign status.out_free = !m_tvalid || m_tready;

endmodule

### test/tb_generational_slot_allocator.sv
`timescale 1ns / 100ps

module tb_generational_slot_allocator;
  import gsa_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;  // no operation assigned
  localparam int N_RANDOM   = 1200;
  localparam int HOLD_AT    = 1500;  // receiver hold-off window, in cycles
  localparam int HOLD_LEN   = 300;
  localparam int IDLE_LIMIT = 2000;  // cycles with no handshake before giving up
  localparam int PAD_W      = DATA_W - IDX_W - SALT_W;

  // Pool state as the allocator sees it
  typedef struct packed {
    logic [SLOTS-1:0]             live;
    logic [SLOTS-1:0][SALT_W-1:0] gen;
    logic [CNT_W-1:0]             top;   // high-water count
    logic [CNT_W-1:0]             used;  // live slots
  } pool_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  index;
    logic [SALT_W-1:0] salt;
  } handle_req_t;

  typedef struct packed {
    logic              ok;
    logic [IDX_W-1:0]  index;
    logic [SALT_W-1:0] salt;
  } handle_rsp_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic              clk;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;  // handle_index, handle_salt, pad
  logic [FUNC_W-1:0] s_tuser = '0;  // func
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;       // result_index, result_salt, pad
  logic [0:0]        m_tuser;       // ok

  handle_req_t pending_req[$];   // requests waiting to be driven
  handle_rsp_t expected_rsp[$];  // results owed by the block, oldest first
  pool_t       gen_pool;         // stimulus-side view, used to pick valid handles
  pool_t       dut_pool;         // predicted pool, advanced on each accepted request
  handle_req_t drv_req;
  handle_req_t req_seen;
  handle_rsp_t want;
  int          n_requests;
  int          offered = 0;
  int          accepted = 0;
  int          errors = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          rx_cyc = 0;
  rx_mode_e    rx_mode = RX_OPEN;

  generational_slot_allocator i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Apply one request to a pool, return the result it yields
  function automatic handle_rsp_t pool_apply(inout pool_t p, input handle_req_t r);
    handle_rsp_t rsp;
    int          pick;
    int          i;
    rsp  = '0;
    pick = SLOTS;
    case (r.func)
      FUNC_ALLOC: begin
        // append at the top when no hole, else lowest dead slot below top
        if (p.used >= p.top) begin
          if (p.top < SLOTS) pick = int'(p.top);
        end else begin
          for (i = 0; i < SLOTS; i++)
            if (pick == SLOTS && i < p.top && !p.live[i]) pick = i;
        end
        if (pick < SLOTS) begin
          if (pick == p.top) p.top = p.top + CNT_W'(1);
          p.live[pick] = 1'b1;
          p.used       = p.used + CNT_W'(1);
          rsp.ok       = 1'b1;
          rsp.index    = IDX_W'(pick);
          rsp.salt     = p.gen[pick];
        end
      end
      FUNC_FREE: begin
        if (r.index < p.top && p.live[r.index]) begin
          p.live[r.index] = 1'b0;
          p.gen[r.index]  = p.gen[r.index] + SALT_W'(1);
          if (CNT_W'(r.index) + CNT_W'(1) == p.top) p.top = p.top - CNT_W'(1);
          if (p.used > 0) p.used = p.used - CNT_W'(1);
          rsp.ok = 1'b1;
        end
      end
      FUNC_LOOKUP: begin
        // dead slots below top still match on generation
        if (r.index < p.top && p.gen[r.index] == r.salt) begin
          rsp.ok    = 1'b1;
          rsp.index = r.index;
          rsp.salt  = p.gen[r.index];
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  task automatic push_req(input logic [FUNC_W-1:0] fn, input logic [IDX_W-1:0] idx,
                          input logic [SALT_W-1:0] salt);
    handle_req_t r;
    r.func  = fn;
    r.index = idx;
    r.salt  = salt;
    void'(pool_apply(gen_pool, r));
    pending_req.push_back(r);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
  end

  // Stimulus build, then end-of-run check
  initial begin : stimulus
    int n;
    int i;
    int roll;
    int k;
    int idx;
    int alloc_pct;
    int live_slots[$];
    gen_pool  = '0;
    dut_pool  = '0;
    alloc_pct = 90;

    // directed: empty pool, holes, stale handles, top shrink, unused code
    push_req(FUNC_LOOKUP, 0, 0);
    push_req(FUNC_FREE, 0, 0);
    push_req(FUNC_ALLOC, 0, 0);
    push_req(FUNC_ALLOC, 6'h3f, 16'hffff);
    push_req(FUNC_LOOKUP, 0, 0);
    push_req(FUNC_LOOKUP, 0, 16'hffff);
    push_req(FUNC_FREE, 0, 16'hffff);
    push_req(FUNC_FREE, 0, 0);
    push_req(FUNC_LOOKUP, 0, 0);
    push_req(FUNC_LOOKUP, 0, 1);
    push_req(FUNC_ALLOC, 0, 0);
    push_req(FUNC_FREE, 1, 0);
    push_req(FUNC_FREE, 6'h3f, 0);
    push_req(FUNC_LOOKUP, 6'h3f, 16'hffff);
    push_req(FUNC_UNUSED, 6'h3f, 16'hffff);
    push_req(FUNC_UNUSED, 0, 0);
    push_req(FUNC_ALLOC, 0, 0);
    push_req(FUNC_LOOKUP, 1, 1);
    push_req(FUNC_ALLOC, 0, 0);
    push_req(FUNC_FREE, 1, 0);
    push_req(FUNC_FREE, 2, 0);
    push_req(FUNC_ALLOC, 0, 0);

    // random: segments drift between filling and draining the pool
    for (n = 0; n < N_RANDOM; n++) begin
      if (n % 150 == 0) alloc_pct = (n == 0) ? 90 : $urandom_range(10, 90);
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        push_req(FUNC_UNUSED, IDX_W'($urandom_range(0, SLOTS - 1)),
                 SALT_W'($urandom_range(0, 65535)));
      end else if (roll < 2 + alloc_pct * 98 / 100) begin
        push_req(FUNC_ALLOC, IDX_W'($urandom_range(0, SLOTS - 1)),
                 SALT_W'($urandom_range(0, 65535)));
      end else if (roll % 2 == 0) begin
        // mostly free a live handle, sometimes a random one
        live_slots.delete();
        for (i = 0; i < SLOTS; i++)
          if (gen_pool.live[i]) live_slots.push_back(i);
        if (live_slots.size() > 0 && $urandom_range(0, 9) < 8)
          idx = live_slots[$urandom_range(0, live_slots.size() - 1)];
        else
          idx = $urandom_range(0, SLOTS - 1);
        push_req(FUNC_FREE, IDX_W'(idx), SALT_W'($urandom_range(0, 65535)));
      end else begin
        // lookup: current handle, stale handle, or noise
        k = $urandom_range(0, 9);
        if (gen_pool.top > 0 && k < 7) begin
          idx = $urandom_range(0, gen_pool.top - 1);
          push_req(FUNC_LOOKUP, IDX_W'(idx),
                   (k < 5) ? gen_pool.gen[idx] : gen_pool.gen[idx] - SALT_W'(1));
        end else begin
          push_req(FUNC_LOOKUP, IDX_W'($urandom_range(0, SLOTS - 1)),
                   SALT_W'($urandom_range(0, 65535)));
        end
      end
    end
    n_requests = pending_req.size();

    while (rst) @(posedge clk);
    while (accepted < n_requests || expected_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb_generational_slot_allocator OK");
    end else begin
      $display("tb_generational_slot_allocator NOT OK");
    end
    $finish;
  end

  // Request driver: bursts with random gaps
  always @(negedge clk) begin
    if (!rst && !(s_tvalid && offered != accepted)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_req.size() > 0) begin
        drv_req = pending_req.pop_front();
        s_tdata  <= {{PAD_W{1'b0}}, drv_req.salt, drv_req.index};
        s_tuser  <= drv_req.func;
        s_tvalid <= 1'b1;
        offered  <= offered + 1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 30);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: stall pattern redrawn at random in segments, one long hold-off
  always @(negedge clk) begin
    rx_cyc <= rx_cyc + 1;
    if (rx_cyc % 200 == 0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
    if (rx_cyc >= HOLD_AT && rx_cyc < HOLD_AT + HOLD_LEN) begin
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:     m_tready <= 1'b1;
        RX_COIN:     m_tready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
        RX_PERIODIC: m_tready <= (rx_cyc % 3 != 0);
        default:     m_tready <= 1'b1;
      endcase
    end
  end

  // Handshake monitor: predict on accepted requests, check results in order
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        req_seen.func  = s_tuser;
        req_seen.index = s_tdata[IDX_W-1:0];
        req_seen.salt  = s_tdata[IDX_W+SALT_W-1:IDX_W];
        expected_rsp.push_back(pool_apply(dut_pool, req_seen));
        accepted = accepted + 1;
      end
      if (m_tvalid && m_tready) begin
        if (expected_rsp.size() == 0) begin
          $error("result with no request outstanding: ok=%0d tdata=%h", m_tuser, m_tdata);
          errors++;
        end else begin
          want = expected_rsp.pop_front();
          if (m_tuser[0] !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, m_tuser[0]);
            errors++;
          end
          if (m_tdata[IDX_W-1:0] !== want.index) begin
            $error("result_index: expected %0d, got %0d", want.index, m_tdata[IDX_W-1:0]);
            errors++;
          end
          if (m_tdata[IDX_W+SALT_W-1:IDX_W] !== want.salt) begin
            $error("result_salt: expected %0d, got %0d", want.salt,
                   m_tdata[IDX_W+SALT_W-1:IDX_W]);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_generational_slot_allocator NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
